// ===== rtl/r2y_pkg.sv =====
package r2y_pkg;

  localparam int MaxDimension = 4096;
  localparam int DimW = $clog2(MaxDimension);
  localparam int SizeW = DimW + 1;
  localparam int CfgW = 13;
  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam int PixW = 8;
  localparam int SumW = 20;
  localparam int QShift = 10;

  localparam logic [CfgW-1:0] WidthReset = CfgW'(640);
  localparam logic [CfgW-1:0] HeightReset = CfgW'(480);
  localparam int MinDimension = 2;

  localparam int LumaOffset = 16;
  localparam int ChromaOffset = 128;
  localparam int PixMax = 255;

  localparam int CoefYR = 263;
  localparam int CoefYG = 516;
  localparam int CoefYB = 100;
  localparam int CoefUR = -152;
  localparam int CoefUG = -298;
  localparam int CoefUB = 450;
  localparam int CoefVR = 450;
  localparam int CoefVG = -377;
  localparam int CoefVB = -73;

  typedef enum logic {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } reg_index_e;

  typedef struct packed {
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
  } frame_size_t;

  typedef struct packed {
    logic chroma;
    logic last;
  } pos_flags_t;

  typedef logic signed [SumW-1:0] sum_t;

  function automatic sum_t weigh(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                                 input logic [PixW-1:0] b, input int cr, input int cg,
                                 input int cb);
    sum_t sr;
    sum_t sg;
    sum_t sb;
    sr = $signed({{(SumW-PixW){1'b0}}, r}) * SumW'(cr);
    sg = $signed({{(SumW-PixW){1'b0}}, g}) * SumW'(cg);
    sb = $signed({{(SumW-PixW){1'b0}}, b}) * SumW'(cb);
    return sr + sg + sb;
  endfunction

  function automatic logic [PixW-1:0] finish(input sum_t sum, input int offset);
    sum_t biased;
    sum_t q;
    sum_t v;
    biased = sum[SumW-1] ? sum + sum_t'((1 << QShift) - 1) : sum;
    q = biased >>> QShift;
    v = q + sum_t'(offset);
    if (v < 0) begin
      return '0;
    end else if (v > sum_t'(PixMax)) begin
      return PixW'(PixMax);
    end
    return v[PixW-1:0];
  endfunction

endpackage

// ===== rtl/r2y_cfg.sv =====
module r2y_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [r2y_pkg::AddrW-1:0]   paddr,
  input  logic [r2y_pkg::DataW-1:0]   pwdata,
  output logic [r2y_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output r2y_pkg::frame_size_t        size_o
);
  import r2y_pkg::*;

  logic [CfgW-1:0] width_q, width_d;
  logic [CfgW-1:0] height_q, height_d;
  reg_index_e      index;
  logic            wr_en;

  assign pready = 1'b1;
  assign index = reg_index_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    width_d = width_q;
    height_d = height_q;
    prdata = '0;
    unique case (index)
      RegFrameWidth: begin
        prdata = DataW'(width_q);
        if (wr_en) width_d = pwdata[CfgW-1:0];
      end
      RegFrameHeight: begin
        prdata = DataW'(height_q);
        if (wr_en) height_d = pwdata[CfgW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
      height_q <= HeightReset;
    end else begin
      width_q <= width_d;
      height_q <= height_d;
    end
  end

  // clamp the programmed size into the supported range
  function automatic logic [SizeW-1:0] limit(input logic [CfgW-1:0] v);
    if (int'(v) < MinDimension) begin
      return SizeW'(MinDimension);
    end else if (int'(v) > MaxDimension) begin
      return SizeW'(MaxDimension);
    end
    return SizeW'(v);
  endfunction

  assign size_o.width = limit(width_q);
  assign size_o.height = limit(height_q);

endmodule

// ===== rtl/r2y_pos.sv =====
module r2y_pos (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  r2y_pkg::frame_size_t  size_i,
  input  logic                  advance_i,
  output r2y_pkg::pos_flags_t   flags_o
);
  import r2y_pkg::*;

  logic [DimW-1:0] col_q, col_d;
  logic [DimW-1:0] row_q, row_d;
  logic            row_end;

  assign row_end = ({1'b0, col_q} + SizeW'(1)) >= size_i.width;
  assign flags_o.chroma = !col_q[0] && !row_q[0];
  assign flags_o.last = row_end && (({1'b0, row_q} + SizeW'(1)) >= size_i.height);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = flags_o.last ? '0 : row_q + DimW'(1);
      end else begin
        col_d = col_q + DimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== rtl/r2y_pipe.sv =====
module r2y_pipe (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  output logic                       accept_o,
  input  r2y_pkg::pos_flags_t        flags_i,
  input  logic [r2y_pkg::PixW-1:0]   red_i,
  input  logic [r2y_pkg::PixW-1:0]   green_i,
  input  logic [r2y_pkg::PixW-1:0]   blue_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [r2y_pkg::PixW-1:0]   luma_o,
  output logic                       chroma_valid_o,
  output logic [r2y_pkg::PixW-1:0]   chroma_blue_o,
  output logic [r2y_pkg::PixW-1:0]   chroma_red_o,
  output logic                       frame_end_o
);
  import r2y_pkg::*;

  // input stage
  logic            s1_valid_q, s1_valid_d;
  logic [PixW-1:0] r_q, g_q, b_q;
  pos_flags_t      flags_q;

  // result stage
  logic            out_valid_q, out_valid_d;
  logic [PixW-1:0] luma_q, luma_d;
  logic [PixW-1:0] cb_q, cb_d;
  logic [PixW-1:0] cr_q, cr_d;
  logic            chroma_q;
  logic            last_q;

  logic s2_ready;
  logic s1_ready;
  logic s2_load;

  assign s2_ready = !out_valid_q || !out_stall_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s2_load = s1_valid_q && s2_ready;
  assign accept_o = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  assign s1_valid_d = accept_o ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_q);
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  always_comb begin
    luma_d = finish(weigh(r_q, g_q, b_q, CoefYR, CoefYG, CoefYB), LumaOffset);
    cb_d = '0;
    cr_d = '0;
    if (flags_q.chroma) begin
      cb_d = finish(weigh(r_q, g_q, b_q, CoefUR, CoefUG, CoefUB), ChromaOffset);
      cr_d = finish(weigh(r_q, g_q, b_q, CoefVR, CoefVG, CoefVB), ChromaOffset);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      r_q <= red_i;
      g_q <= green_i;
      b_q <= blue_i;
      flags_q <= flags_i;
    end
    if (s2_load) begin
      luma_q <= luma_d;
      cb_q <= cb_d;
      cr_q <= cr_d;
      chroma_q <= flags_q.chroma;
      last_q <= flags_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign luma_o = luma_q;
  assign chroma_valid_o = chroma_q;
  assign chroma_blue_o = cb_q;
  assign chroma_red_o = cr_q;
  assign frame_end_o = last_q;

endmodule

// ===== rtl/rgb_to_yuv420_converter.sv =====
// Converts a raster-order RGB pixel stream to BT.601 studio-range YCbCr 4:2:0.
// One word in is one pixel; one word out carries its luma, and on even rows and
// even columns also Cb and Cr (chroma_valid high; otherwise both read as zero).
// frame_end marks the last pixel of the frame set by frame_width (address 0)
// and frame_height (address 4); sizes below 2 act as 2 and above 4096 as 4096.
// Size writes never reset the position counters, so program them between frames.
// Throughput is one pixel per clock while out_stall_i is low; an accepted pixel sits
// in the input register and shows on the outputs with out_valid_o once it moves on
// into the result register.
module rgb_to_yuv420_converter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [r2y_pkg::AddrW-1:0]   paddr,
  input  logic [r2y_pkg::DataW-1:0]   pwdata,
  output logic [r2y_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [r2y_pkg::PixW-1:0]    red_i,
  input  logic [r2y_pkg::PixW-1:0]    green_i,
  input  logic [r2y_pkg::PixW-1:0]    blue_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [r2y_pkg::PixW-1:0]    luma_o,
  output logic                        chroma_valid_o,
  output logic [r2y_pkg::PixW-1:0]    chroma_blue_o,
  output logic [r2y_pkg::PixW-1:0]    chroma_red_o,
  output logic                        frame_end_o
);
  import r2y_pkg::*;

  frame_size_t size;
  pos_flags_t  flags;
  logic        accept;

  r2y_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_o  (size)
  );

  r2y_pos u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .size_i    (size),
    .advance_i (accept),
    .flags_o   (flags)
  );

  r2y_pipe u_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .accept_o       (accept),
    .flags_i        (flags),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .luma_o         (luma_o),
    .chroma_valid_o (chroma_valid_o),
    .chroma_blue_o  (chroma_blue_o),
    .chroma_red_o   (chroma_red_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

// ===== rtl/r2y_checker.sv =====
module r2y_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [r2y_pkg::PixW-1:0]    luma_o,
  input logic                        chroma_valid_o,
  input logic [r2y_pkg::PixW-1:0]    chroma_blue_o,
  input logic [r2y_pkg::PixW-1:0]    chroma_red_o
);
  import r2y_pkg::*;

  // a stalled output word stays valid and keeps its luma and blue chroma
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(luma_o) && $stable(chroma_blue_o))
    else $error("output word changed while stalled");

  // input back-pressure only comes from a stalled full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // studio-range luma
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> luma_o >= PixW'(LumaOffset) && luma_o <= PixW'(235))
    else $error("luma out of studio range");

  // decimated pixels carry no chroma
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !chroma_valid_o |-> chroma_blue_o == '0 && chroma_red_o == '0)
    else $error("chroma present on a decimated pixel");

endmodule

bind rgb_to_yuv420_converter r2y_checker u_r2y_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .luma_o         (luma_o),
  .chroma_valid_o (chroma_valid_o),
  .chroma_blue_o  (chroma_blue_o),
  .chroma_red_o   (chroma_red_o)
);

// ===== dv/rgb_to_yuv420_converter_checker.sv =====
`timescale 1ns / 1ps
module rgb_to_yuv420_converter_checker
  import r2y_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic [DataW-1:0] prdata,
  input  logic             pready,
  input  logic             in_valid_i,
  input  logic             in_stall_o,
  input  logic [PixW-1:0]  red_i,
  input  logic [PixW-1:0]  green_i,
  input  logic [PixW-1:0]  blue_i,
  input  logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic [PixW-1:0]  luma_o,
  input  logic             chroma_valid_o,
  input  logic [PixW-1:0]  chroma_blue_o,
  input  logic [PixW-1:0]  chroma_red_o,
  input  logic             frame_end_o,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [PixW-1:0] luma;
    logic            chroma_valid;
    logic [PixW-1:0] chroma_blue;
    logic [PixW-1:0] chroma_red;
    logic            frame_end;
  } yuv_word_t;

  logic [CfgW-1:0] width_q;
  logic [CfgW-1:0] height_q;
  int              column_q;
  int              row_q;
  int              fails;
  yuv_word_t       yuv_expected_q[$];

  function automatic int bound_dim(input logic [CfgW-1:0] v);
    if (v < CfgW'(MinDimension)) begin
      return MinDimension;
    end else if (v > CfgW'(MaxDimension)) begin
      return MaxDimension;
    end
    return int'(v);
  endfunction

  function automatic logic [PixW-1:0] scale_sample(input int acc, input int offset);
    int v;
    v = acc / 1024 + offset;
    if (v < 0) begin
      return '0;
    end else if (v > 255) begin
      return 8'd255;
    end
    return v[PixW-1:0];
  endfunction

  task automatic check_field(input string name, input logic [PixW-1:0] want_v,
                             input logic [PixW-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    yuv_word_t       want;
    logic [CfgW-1:0] reg_value;
    int              w;
    int              h;
    int              r;
    int              g;
    int              b;
    logic            row_end;
    if (!rst_ni) begin
      width_q = WidthReset;
      height_q = HeightReset;
      column_q = 0;
      row_q = 0;
      fails = 0;
      yuv_expected_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_index_e'(paddr[2]))
            RegFrameWidth: width_q = pwdata[CfgW-1:0];
            RegFrameHeight: height_q = pwdata[CfgW-1:0];
            default: ;
          endcase
        end else begin
          reg_value = (reg_index_e'(paddr[2]) == RegFrameHeight) ? height_q : width_q;
          if (prdata !== DataW'(reg_value)) begin
            $error("prdata: expected %0d, actual %0d", reg_value, prdata);
            fails++;
          end
        end
      end

      if (out_valid_o && !out_stall_i) begin
        if (yuv_expected_q.size() == 0) begin
          $error("output word with none expected: luma %0d", luma_o);
          fails++;
        end else begin
          want = yuv_expected_q.pop_front();
          check_field("luma", want.luma, luma_o);
          check_field("chroma_valid", PixW'(want.chroma_valid), PixW'(chroma_valid_o));
          check_field("chroma_blue", want.chroma_blue, chroma_blue_o);
          check_field("chroma_red", want.chroma_red, chroma_red_o);
          check_field("frame_end", PixW'(want.frame_end), PixW'(frame_end_o));
        end
      end

      if (in_valid_i && !in_stall_o) begin
        w = bound_dim(width_q);
        h = bound_dim(height_q);
        r = red_i;
        g = green_i;
        b = blue_i;
        row_end = (column_q + 1) >= w;
        // q10 bt.601 studio range
        want.luma = scale_sample(263 * r + 516 * g + 100 * b, 16);
        want.chroma_valid = (column_q % 2 == 0) && (row_q % 2 == 0);
        want.chroma_blue = want.chroma_valid ?
                           scale_sample(-152 * r - 298 * g + 450 * b, 128) : '0;
        want.chroma_red = want.chroma_valid ?
                          scale_sample(450 * r - 377 * g - 73 * b, 128) : '0;
        want.frame_end = row_end && ((row_q + 1) >= h);
        yuv_expected_q.push_back(want);
        if (row_end) begin
          column_q = 0;
          row_q = want.frame_end ? 0 : row_q + 1;
        end else begin
          column_q++;
        end
      end

      pending_o <= yuv_expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== dv/rgb_to_yuv420_converter_tb.sv =====
`timescale 1ns / 1ps
module rgb_to_yuv420_converter_tb;
  import r2y_pkg::*;

  typedef enum int {
    IdleNone,
    IdleLight,
    IdleHeavy
  } idle_mode_e;

  localparam int RandomPixels = 700;
  localparam int MaxWait = 18;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [PixW-1:0]  red_i = '0;
  logic [PixW-1:0]  green_i = '0;
  logic [PixW-1:0]  blue_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [PixW-1:0]  luma_o;
  logic             chroma_valid_o;
  logic [PixW-1:0]  chroma_blue_o;
  logic [PixW-1:0]  chroma_red_o;
  logic             frame_end_o;

  int         mismatch_count;
  int         words_pending;
  idle_mode_e idle_mode = IdleHeavy;
  int         pixels_sent = 0;
  int         random_pixels = 0;
  int         size_writes = 0;

  rgb_to_yuv420_converter dut (.*);

  rgb_to_yuv420_converter_checker checker_i (
    .fail_count_o(mismatch_count),
    .pending_o   (words_pending),
    .*
  );

  always #6 clk_i = ~clk_i;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int draw_wait();
    case (idle_mode)
      IdleNone: return 0;
      IdleLight: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, MaxWait) : 0;
      default: return $urandom_range(0, MaxWait);
    endcase
  endfunction

  function automatic logic [PixW-1:0] pick_channel();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    end
    return PixW'($urandom_range(0, 255));
  endfunction

  function automatic logic [CfgW-1:0] pick_dim();
    if ($urandom_range(0, 15) == 0) begin
      return CfgW'($urandom_range(0, 8191));
    end
    return CfgW'($urandom_range(0, 9));
  endfunction

  task automatic send_pixel(input logic [PixW-1:0] r, input logic [PixW-1:0] g,
                            input logic [PixW-1:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pixels_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel(pick_channel(), pick_channel(), pick_channel());
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input reg_index_e idx, input logic wr, input logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_size(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h,
                          input bit write_w, input bit write_h);
    logic [DataW-1:0] data;
    if (write_w) begin
      data = $urandom();
      data[CfgW-1:0] = w;
      apb_access(RegFrameWidth, 1'b1, data);
      size_writes++;
    end
    if (write_h) begin
      data = $urandom();
      data[CfgW-1:0] = h;
      apb_access(RegFrameHeight, 1'b1, data);
      size_writes++;
    end
    apb_access(RegFrameWidth, 1'b0, '0);
    apb_access(RegFrameHeight, 1'b0, '0);
  endtask

  initial begin
    int  count;
    bit  write_w;
    bit  write_h;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // reset frame size, primaries and extremes
    apb_access(RegFrameWidth, 1'b0, '0);
    apb_access(RegFrameHeight, 1'b0, '0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    wait_idle();

    // shrink mid-row: column already past the new width
    set_size(13'd3, 13'd3, 1'b1, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd2, 8'd4);
    send_pixel(8'd8, 8'd16, 8'd32);
    send_pixel(8'd64, 8'd128, 8'd1);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd255);
    wait_idle();

    // below-minimum sizes act as 2x2
    set_size(13'd1, 13'd0, 1'b1, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    wait_idle();

    // above-maximum sizes act as 4096
    set_size(13'd8191, 13'd4097, 1'b1, 1'b1);
    send_random(3);

    while (random_pixels < RandomPixels) begin
      wait_idle();
      idle_mode = idle_mode_e'($urandom_range(0, 2));
      write_w = $urandom_range(0, 3) != 0;
      write_h = $urandom_range(0, 3) != 0;
      set_size(pick_dim(), pick_dim(), write_w, write_h);
      count = $urandom_range(4, 60);
      send_random(count);
      random_pixels += count;
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("%0d pixels sent (%0d in random phases) over %0d frame size writes",
             pixels_sent, random_pixels, size_writes);
    $display("sizes 0 through 8191, mid-frame size changes, random stalls on both sides");
    if (mismatch_count == 0) begin
      $display("rgb_to_yuv420_converter regression: pass");
    end else begin
      $display("rgb_to_yuv420_converter regression: fail");
    end
    $finish;
  end

  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  initial begin
    #50ms;
    $display("rgb_to_yuv420_converter regression: fail");
    $finish;
  end

endmodule
